@@ hw/rtl/optt_pkg.sv @@
// Shared types and codes for the timer table unit.
`default_nettype none
package optt_pkg;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned KIND_W = 3;

  localparam logic [OP_W-1:0] OP_TICK       = 3'd0;
  localparam logic [OP_W-1:0] OP_SCHED_ONCE = 3'd1;
  localparam logic [OP_W-1:0] OP_SCHED_REP  = 3'd2;
  localparam logic [OP_W-1:0] OP_CANCEL     = 3'd3;
  localparam logic [OP_W-1:0] OP_CANCEL_ALL = 3'd4;

  localparam logic [KIND_W-1:0] KIND_FIRED  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SCHED  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FULL   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CANCEL = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TICK   = 3'd4;

  typedef struct packed {
    logic shift;
    logic wr;
  } optt_ctl_t;

endpackage
`default_nettype wire

@@ hw/rtl/optt_cell.sv @@
// One table slot: holds an entry, takes its upper neighbor on shift or a write at its index.
`default_nettype none
module optt_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned ENT_W = 73,
  parameter int unsigned CNT_W = 5
) (
  input  wire                    clk,
  input  optt_pkg::optt_ctl_t    ctl,
  input  wire  [CNT_W-1:0]       pos,
  input  wire  [ENT_W-1:0]       wdata,
  input  wire  [ENT_W-1:0]       nb_ent,
  output logic [ENT_W-1:0]       ent
);
  import optt_pkg::*;

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic [ENT_W-1:0] ent_r;

  always_ff @(posedge clk) begin
    if (ctl.wr && (pos == MY_IDX)) begin
      ent_r <= wdata;
    end else if (ctl.shift) begin
      ent_r <= nb_ent;
    end
  end

  assign ent = ent_r;

endmodule
`default_nettype wire

@@ hw/rtl/optt_head.sv @@
// Head-of-chain update: tick add/fire/rearm or cancel tag match.
`default_nettype none
module optt_head #(
  parameter int unsigned TIME_BITS = 32,
  parameter int unsigned TAG_BITS  = 8
) (
  input  wire  [2*TIME_BITS+TAG_BITS:0] ent,
  input  wire  [TIME_BITS-1:0]          amt,
  input  wire  [TAG_BITS-1:0]           ctag,
  input  wire                           is_tick,
  output logic [2*TIME_BITS+TAG_BITS:0] nxt_ent,
  output logic                          keep,
  output logic                          fire
);
  import optt_pkg::*;

  localparam int unsigned T = TIME_BITS;

  logic [T-1:0]        el;
  logic [T-1:0]        dly;
  logic [TAG_BITS-1:0] tg;
  logic                rep;
  logic [T:0]          sum;
  logic [T-1:0]        e_sat;
  logic [T:0]          diff;
  logic                reached;
  logic [T-1:0]        el_nxt;

  always_comb begin
    el      = ent[T-1:0];
    dly     = ent[2*T-1:T];
    tg      = ent[2*T+TAG_BITS-1:2*T];
    rep     = ent[2*T+TAG_BITS];
    sum     = {1'b0, el} + {1'b0, amt};
    e_sat   = sum[T] ? {T{1'b1}} : sum[T-1:0];
    diff    = {1'b0, e_sat} - {1'b0, dly};
    reached = !diff[T];
    if (is_tick) begin
      fire   = reached;
      keep   = !reached || rep;
      el_nxt = (reached && rep) ? diff[T-1:0] : e_sat;
    end else begin
      fire   = 1'b0;
      keep   = (tg != ctag);
      el_nxt = el;
    end
    nxt_ent = {rep, tg, dly, el_nxt};
  end

endmodule
`default_nettype wire

@@ hw/rtl/one_shot_and_periodic_timer_table_unit.sv @@
// Timer table top: chain of slot cells, head update unit, sequencer and output register.
// Schedule, cancel all and trivial ops give their result in the cycle after acceptance.
// Tick and cancel by tag walk the live entries through the head cell, one per cycle unless
// the output stalls; a final S_FIN step then registers the summary result.
// Throughput: one item at a time; the next input is taken once the final result is registered and the output is free.
// Reset: rst_n (synchronous, active low) empties the table and clears control; slots hold no reset.
`default_nettype none
module one_shot_and_periodic_timer_table_unit #(
  parameter int unsigned SLOTS     = 16,
  parameter int unsigned TIME_BITS = 32,
  parameter int unsigned TAG_BITS  = 8
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [39:0] in_tdata,   // tag[7:0], amount[39:8]
  input  wire  [2:0]  in_tuser,   // op[2:0]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata,  // fired_tag[7:0], was_repeating[8], item_count[15:9]
  output logic [2:0]  out_tuser,  // result_kind[2:0]
  output logic        out_tlast   // last
);
  import optt_pkg::*;

  localparam int unsigned T     = TIME_BITS;
  localparam int unsigned ENT_W = 2 * TIME_BITS + TAG_BITS + 1;
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOTS);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_PASS = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  live_r, live_nxt;
  logic [CNT_W-1:0]  ins_r, ins_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  w_r, w_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              tick_r, tick_nxt;
  logic [T-1:0]      amt_r, amt_nxt;
  logic [TAG_BITS-1:0] ctag_r, ctag_nxt;

  logic              ov_r, ov_nxt;
  logic [KIND_W-1:0] okind_r, okind_nxt;
  logic [7:0]        otag_r, otag_nxt;
  logic              orep_r, orep_nxt;
  logic [6:0]        ocnt_r, ocnt_nxt;
  logic              olast_r, olast_nxt;

  logic [OP_W-1:0]     in_op;
  logic [TAG_BITS+7:0] tag_w;
  logic [TAG_BITS-1:0] in_tag_m;
  logic [TAG_BITS+7:0] in_tag_x;
  logic [T+31:0]       amt_w;
  logic [T-1:0]        in_amt_s;
  logic                out_free;
  logic                accept;

  optt_ctl_t         ctl;
  logic [CNT_W-1:0]  pos;
  logic [ENT_W-1:0]  wdata;
  logic [ENT_W-1:0]  chain [SLOTS];

  logic [ENT_W-1:0]  hd_nxt;
  logic              hd_keep;
  logic              hd_fire;
  logic [TAG_BITS+7:0] hd_tag_w;

  assign in_op    = in_tuser;
  assign tag_w    = {{TAG_BITS{1'b0}}, in_tdata[7:0]};
  assign in_tag_m = tag_w[TAG_BITS-1:0];
  assign in_tag_x = {8'h00, in_tag_m};
  assign amt_w    = {{T{1'b0}}, in_tdata[39:8]};
  assign in_amt_s = (|(amt_w >> T)) ? {T{1'b1}} : amt_w[T-1:0];
  assign hd_tag_w = {8'h00, chain[0][2*T+TAG_BITS-1:2*T]};

  assign out_free  = !ov_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign accept    = in_tvalid && in_tready;

  optt_head #(
    .TIME_BITS (TIME_BITS),
    .TAG_BITS  (TAG_BITS)
  ) u_head (
    .ent     (chain[0]),
    .amt     (amt_r),
    .ctag    (ctag_r),
    .is_tick (tick_r),
    .nxt_ent (hd_nxt),
    .keep    (hd_keep),
    .fire    (hd_fire)
  );

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic [ENT_W-1:0] nb;
    if (i == SLOTS - 1) begin : g_tail
      assign nb = chain[i];
    end else begin : g_mid
      assign nb = chain[i+1];
    end
    optt_cell #(
      .IDX   (i),
      .ENT_W (ENT_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .pos    (pos),
      .wdata  (wdata),
      .nb_ent (nb),
      .ent    (chain[i])
    );
  end

  always_comb begin
    state_nxt = state_r;
    live_nxt  = live_r;
    ins_nxt   = ins_r;
    rem_nxt   = rem_r;
    w_nxt     = w_r;
    cnt_nxt   = cnt_r;
    tick_nxt  = tick_r;
    amt_nxt   = amt_r;
    ctag_nxt  = ctag_r;
    ov_nxt    = ov_r && !out_tready;
    okind_nxt = okind_r;
    otag_nxt  = otag_r;
    orep_nxt  = orep_r;
    ocnt_nxt  = ocnt_r;
    olast_nxt = olast_r;
    ctl       = '0;
    pos       = ins_r;
    wdata     = hd_nxt;

    unique case (state_r)
      S_IDLE: begin
        pos   = live_r;
        wdata = {(in_op == OP_SCHED_REP), in_tag_m, in_amt_s, {T{1'b0}}};
        if (accept) begin
          amt_nxt  = in_amt_s;
          ctag_nxt = in_tag_m;
          tick_nxt = (in_op == OP_TICK);
          rem_nxt  = live_r - 1'b1;
          ins_nxt  = live_r - 1'b1;
          w_nxt    = '0;
          cnt_nxt  = '0;
          okind_nxt = KIND_CANCEL;
          otag_nxt  = '0;
          orep_nxt  = 1'b0;
          ocnt_nxt  = '0;
          olast_nxt = 1'b1;
          unique case (in_op)
            OP_SCHED_ONCE, OP_SCHED_REP: begin
              ov_nxt   = 1'b1;
              otag_nxt = in_tag_x[7:0];
              if (live_r >= FULL_CNT) begin
                okind_nxt = KIND_FULL;
              end else begin
                okind_nxt = KIND_SCHED;
                ctl.wr    = 1'b1;
                live_nxt  = live_r + 1'b1;
              end
            end
            OP_CANCEL_ALL: begin
              ov_nxt   = 1'b1;
              ocnt_nxt = 7'(live_r);
              live_nxt = '0;
            end
            OP_CANCEL: begin
              if ((in_tag_m == '0) || (live_r == '0)) begin
                ov_nxt = 1'b1;
              end else begin
                state_nxt = S_PASS;
              end
            end
            OP_TICK: begin
              if (live_r == '0) begin
                ov_nxt    = 1'b1;
                okind_nxt = KIND_TICK;
              end else begin
                state_nxt = S_PASS;
              end
            end
            default: ;
          endcase
        end
      end
      S_PASS: begin
        if (out_free) begin
          ctl.shift = 1'b1;
          ctl.wr    = hd_keep;
          if (hd_keep) begin
            w_nxt = w_r + 1'b1;
          end else begin
            ins_nxt = ins_r - 1'b1;
          end
          if (hd_fire || (!tick_r && !hd_keep)) begin
            cnt_nxt = cnt_r + 1'b1;
          end
          if (hd_fire) begin
            ov_nxt    = 1'b1;
            okind_nxt = KIND_FIRED;
            otag_nxt  = hd_tag_w[7:0];
            orep_nxt  = hd_nxt[2*T+TAG_BITS];
            ocnt_nxt  = '0;
            olast_nxt = 1'b0;
          end
          if (rem_r == '0) begin
            state_nxt = S_FIN;
          end else begin
            rem_nxt = rem_r - 1'b1;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          okind_nxt = tick_r ? KIND_TICK : KIND_CANCEL;
          otag_nxt  = '0;
          orep_nxt  = 1'b0;
          ocnt_nxt  = 7'(cnt_r);
          olast_nxt = 1'b1;
          live_nxt  = w_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      live_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      live_r  <= live_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ins_r   <= ins_nxt;
    rem_r   <= rem_nxt;
    w_r     <= w_nxt;
    cnt_r   <= cnt_nxt;
    tick_r  <= tick_nxt;
    amt_r   <= amt_nxt;
    ctag_r  <= ctag_nxt;
    okind_r <= okind_nxt;
    otag_r  <= otag_nxt;
    orep_r  <= orep_nxt;
    ocnt_r  <= ocnt_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = okind_r;
  assign out_tdata  = {ocnt_r, orep_r, otag_r};
  assign out_tlast  = olast_r;

  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= FULL_CNT)
    else $error("live count above table size");

  a_ins_track: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PASS) |-> ({1'b0, ins_r} == ({1'b0, rem_r} + {1'b0, w_r})))
    else $error("insert pointer out of step with walk");

  a_cancel_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PASS && !tick_r) |->
      (({2'b0, w_r} + {2'b0, cnt_r} + {2'b0, rem_r} + 1'b1) == {2'b0, live_r}))
    else $error("cancel walk lost or duplicated entries");

  a_sched_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_op == OP_SCHED_ONCE || in_op == OP_SCHED_REP) && live_r < FULL_CNT)
      |=> (live_r == $past(live_r) + 1'b1))
    else $error("schedule did not append");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_tready) |=> ov_r)
    else $error("pending result dropped");

endmodule
`default_nettype wire
